[hdl/pmh_pkg.sv]
// Shared constants, types and the pt bin edge table of the pair mass histogrammer.
package pmh_pkg;

	localparam int PT_BINS     = 28;
	localparam int MASS_BINS   = 50;
	localparam int COUNT_WIDTH = 32;

	localparam int EDGE_COUNT  = 29;
	localparam int PT_USED     = (PT_BINS < EDGE_COUNT - 1) ? PT_BINS : EDGE_COUNT - 1;
	localparam int MASS_RANGE  = 6144;
	localparam int MASS_SHIFT  = 11;
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_THIRD = ((1 << RECIP_SHIFT) + 2) / 3;

	localparam int PT_W    = (PT_BINS > 1) ? $clog2(PT_BINS) : 1;
	localparam int MBIN_W  = $clog2(MASS_BINS + 1);
	localparam int ADDR_W  = 1 + PT_W + MBIN_W;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int MPROD_W = 16 + MBIN_W;
	localparam int Q_W     = $clog2(3 * MASS_BINS + 1);

	// Pt bin edges in 1/1024 GeV; bin b covers [edge b, edge b+1).
	localparam logic [15:0] PT_EDGES [EDGE_COUNT] = '{
		16'd2560,  16'd3072,  16'd3584,  16'd4096,  16'd4608,  16'd5120,
		16'd5632,  16'd6144,  16'd6656,  16'd7168,  16'd7680,  16'd8192,
		16'd8704,  16'd9216,  16'd9728,  16'd10240, 16'd12288, 16'd14336,
		16'd16384, 16'd18432, 16'd20480, 16'd22528, 16'd24576, 16'd26624,
		16'd28672, 16'd30720, 16'd35840, 16'd40960, 16'd46080
	};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_LOOK,
		ST_MERGE
	} state_t;

	typedef enum logic {
		OP_FILL = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic div;
		logic look;
		logic merge;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} status_t;

endpackage

[hdl/pmh_ram.sv]
// Generic single-write, single-read memory with registered read data.
module pmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/pmh_ctrl.sv]
// Controller state machine: clearing pass, request sequencing and result valid.
module pmh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  pmh_pkg::status_t status,
	output pmh_pkg::cmd_t    cmd
);
	import pmh_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_MERGE;
			end
			ST_MERGE: begin
				// The previous result must have left before the new one overwrites it.
				if (!(out_valid_q && out_stall)) begin
					cmd.merge   = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/pmh_dpath.sv]
// Datapath: request registers, pt and mass binning, counter memory and result registers.
module pmh_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  pmh_pkg::cmd_t    cmd,
	output pmh_pkg::status_t status,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_wr_data,
	input  logic             operation,
	input  logic [15:0]      pair_pt,
	input  logic [15:0]      pair_mass,
	input  logic [2:0]       sector,
	input  logic             trigger_first,
	input  logic             trigger_second,
	input  logic             event_live,
	input  logic             read_group,
	input  logic [4:0]       read_pt_bin,
	input  logic [5:0]       read_mass_bin,
	output logic             accepted,
	output logic             group,
	output logic [4:0]       pt_bin_found,
	output logic [5:0]       mass_bin_found,
	output logic [31:0]      count
);
	import pmh_pkg::*;

	logic [2:0]  last_sector_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Request registers.
	logic        op_q;
	logic [15:0] pt_q;
	logic [15:0] mass_q;
	logic [2:0]  sec_q;
	logic        pass_q;
	logic        rg_q;
	logic [4:0]  rp_q;
	logic [5:0]  rm_q;

	// Binning.
	logic              hit_q;
	logic [PT_W-1:0]   pbin_q;
	logic              grp_q;
	logic              over_q;
	logic [MPROD_W-1:0] mprod_q;
	logic [MBIN_W-1:0] mbin_q;

	logic              hit_c;
	logic [PT_W-1:0]   pbin_c;
	logic [Q_W-1:0]    quot_c;
	logic [Q_W+RECIP_SHIFT-1:0] recip_prod_c;

	// Memory access.
	logic              go_c;
	logic              fill_ok_c, fill_ok_q;
	logic              rd_ok_c, rd_ok_q;
	logic [ADDR_W-1:0] addr_c, addr_q;
	logic [COUNT_WIDTH-1:0] rdata, cnt_new;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sector_q <= 3'd5;
			clr_addr_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				last_sector_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign status.clear_done = &clr_addr_q;

	always_comb begin
		hit_c  = 1'b0;
		pbin_c = '0;
		for (int b = 0; b < PT_USED; b++) begin
			if (pt_q >= PT_EDGES[b] && pt_q < PT_EDGES[b + 1]) begin
				hit_c  = 1'b1;
				pbin_c = PT_W'(b);
			end
		end
	end

	// floor(mass * MASS_BINS / 6144) as a shift by 2048 and a reciprocal multiply by 1/3.
	assign quot_c       = Q_W'(mprod_q >> MASS_SHIFT);
	assign recip_prod_c = (Q_W + RECIP_SHIFT)'(quot_c) * (Q_W + RECIP_SHIFT)'(RECIP_THIRD);

	always_comb begin
		fill_ok_c = (op_q == OP_FILL) && pass_q && hit_q;
		rd_ok_c   = (op_q == OP_READ) && (int'(rp_q) < PT_BINS) && (int'(rm_q) <= MASS_BINS);
		go_c      = fill_ok_c || rd_ok_c;
		if (op_q == OP_READ) begin
			addr_c = {rg_q, PT_W'(rp_q), MBIN_W'(rm_q)};
		end else begin
			addr_c = {grp_q, pbin_q, mbin_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			pt_q   <= pair_pt;
			mass_q <= pair_mass;
			sec_q  <= sector;
			pass_q <= (trigger_first || trigger_second) && event_live;
			rg_q   <= read_group;
			rp_q   <= read_pt_bin;
			rm_q   <= read_mass_bin;
		end
		if (cmd.calc) begin
			hit_q   <= hit_c;
			pbin_q  <= pbin_c;
			grp_q   <= (sec_q <= last_sector_q) ? 1'b0 : 1'b1;
			over_q  <= (int'(mass_q) >= MASS_RANGE);
			mprod_q <= MPROD_W'(mass_q) * MPROD_W'(MASS_BINS);
		end
		if (cmd.div) begin
			mbin_q <= over_q ? MBIN_W'(MASS_BINS) : MBIN_W'(recip_prod_c >> RECIP_SHIFT);
		end
		if (cmd.look) begin
			fill_ok_q <= fill_ok_c;
			rd_ok_q   <= rd_ok_c;
			addr_q    <= addr_c;
		end
		if (cmd.merge) begin
			accepted <= fill_ok_q;
			if (op_q == OP_READ) begin
				group          <= rg_q;
				pt_bin_found   <= rp_q;
				mass_bin_found <= rm_q;
				count          <= rd_ok_q ? 32'(rdata) : '0;
			end else if (fill_ok_q) begin
				group          <= grp_q;
				pt_bin_found   <= 5'(pbin_q);
				mass_bin_found <= 6'(mbin_q);
				count          <= 32'(cnt_new);
			end else begin
				group          <= 1'b0;
				pt_bin_found   <= '0;
				mass_bin_found <= '0;
				count          <= '0;
			end
		end
	end

	// Counters saturate at their all-ones value.
	assign cnt_new = (&rdata) ? rdata : rdata + 1'b1;

	always_comb begin
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.merge && fill_ok_q;
			ram_waddr = addr_q;
			ram_wdata = cnt_new;
		end
	end

	pmh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_counters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.look && go_c),
		.raddr(addr_c),
		.rdata(rdata)
	);

endmodule

[hdl/pair_mass_histogrammer.sv]
// Pair mass histogrammer top level: controller, datapath and checks.
// After reset the block clears all 4096 entries of its counter memory, one entry a cycle,
// (2 groups x 32 pt rows x 64 mass columns) and holds in_stall high meanwhile; the sector
// register may be written during that time. Each request then goes from acceptance to the
// next acceptance through these steps: it is registered, the pt bin is searched and the
// mass product formed, the divide by 6144 is done, the counter is read, and a counted fill
// writes back the incremented counter while the result is loaded. That last step waits
// while an earlier result is still held by out_stall. The next request is taken while an
// earlier result still waits on out_stall.
module pair_mass_histogrammer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] pair_pt,
	input  logic [15:0] pair_mass,
	input  logic [2:0]  sector,
	input  logic        trigger_first,
	input  logic        trigger_second,
	input  logic        event_live,
	input  logic        read_group,
	input  logic [4:0]  read_pt_bin,
	input  logic [5:0]  read_mass_bin,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        group,
	output logic [4:0]  pt_bin_found,
	output logic [5:0]  mass_bin_found,
	output logic [31:0] count
);
	import pmh_pkg::*;

	cmd_t    cmd;
	status_t status;

	pmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pmh_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.operation     (operation),
		.pair_pt       (pair_pt),
		.pair_mass     (pair_mass),
		.sector        (sector),
		.trigger_first (trigger_first),
		.trigger_second(trigger_second),
		.event_live    (event_live),
		.read_group    (read_group),
		.read_pt_bin   (read_pt_bin),
		.read_mass_bin (read_mass_bin),
		.accepted      (accepted),
		.group         (group),
		.pt_bin_found  (pt_bin_found),
		.mass_bin_found(mass_bin_found),
		.count         (count)
	);

	// Once a request is taken the block is busy until its result has been loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while the previous one is still in progress");

	// A counted fill always reports bins that lie inside the histogram.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |->
			(int'(pt_bin_found) < PT_BINS) && (int'(mass_bin_found) <= MASS_BINS))
		else $error("accepted fill reports a bin outside the histogram");

	// A new result is only loaded in the cycle after the block was working on a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

endmodule

[tb/pair_mass_histogrammer_test.sv]
// Self-checking testbench for the pair mass histogrammer, with its own model of the counters.
module pair_mass_histogrammer_test;
	import pmh_pkg::*;

	localparam int PT_ROWS      = 28;
	localparam int MASS_COLS    = 50;
	localparam int MASS_SPAN    = 6144;
	localparam int PHASES       = 4;
	localparam int PHASE_ITEMS  = 362;
	localparam int RUN_LIMIT    = 900000;

	// Pt bin edges in 1/1024 GeV; bin b covers [edge b, edge b+1).
	localparam logic [15:0] PT_EDGE_TAB [29] = '{
		16'd2560,  16'd3072,  16'd3584,  16'd4096,  16'd4608,  16'd5120,
		16'd5632,  16'd6144,  16'd6656,  16'd7168,  16'd7680,  16'd8192,
		16'd8704,  16'd9216,  16'd9728,  16'd10240, 16'd12288, 16'd14336,
		16'd16384, 16'd18432, 16'd20480, 16'd22528, 16'd24576, 16'd26624,
		16'd28672, 16'd30720, 16'd35840, 16'd40960, 16'd46080
	};

	typedef struct packed {
		op_t         op;
		logic [15:0] pt;
		logic [15:0] mass;
		logic [2:0]  sector;
		logic        trig_a;
		logic        trig_b;
		logic        live;
		logic        rd_group;
		logic [4:0]  rd_pt;
		logic [5:0]  rd_mass;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        group;
		logic [4:0]  pt_bin;
		logic [5:0]  mass_bin;
		logic [31:0] count;
	} result_t;

	typedef struct packed {
		req_t    req;
		logic    typed;
		result_t want;
	} row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// Reads straight after reset, including an address beyond the table.
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd27, 6'd50},
		  1'b1, '{1'b0, 1'b1, 5'd27, 6'd50, 32'd0}},
		'{'{OP_READ, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 6'd63},
		  1'b1, '{1'b0, 1'b1, 5'd31, 6'd63, 32'd0}},
		// Fills that the cuts or the pt range reject.
		'{'{OP_FILL, 16'd2560, 16'd0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		'{'{OP_FILL, 16'd2560, 16'd0, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		'{'{OP_FILL, 16'd2559, 16'd100, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		'{'{OP_FILL, 16'd46080, 16'd100, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		'{'{OP_FILL, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 6'd63},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd0}},
		// Accepted fills at the ends of both axes and on the group boundary, then a read-back.
		'{'{OP_FILL, 16'd2560, 16'd0, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b1, 1'b0, 5'd0, 6'd0, 32'd1}},
		'{'{OP_FILL, 16'd46079, 16'd6143, 3'd7, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b1, 1'b1, 5'd27, 6'd49, 32'd1}},
		'{'{OP_FILL, 16'd46079, 16'd6144, 3'd6, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b1, 1'b1, 5'd27, 6'd50, 32'd1}},
		'{'{OP_FILL, 16'd10240, 16'hFFFF, 3'd5, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b1, 1'b0, 5'd15, 6'd50, 32'd1}},
		'{'{OP_FILL, 16'd10240, 16'hFFFF, 3'd5, 1'b1, 1'b0, 1'b1, 1'b1, 5'd31, 6'd63},
		  1'b1, '{1'b1, 1'b0, 5'd15, 6'd50, 32'd2}},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd15, 6'd50},
		  1'b1, '{1'b0, 1'b0, 5'd15, 6'd50, 32'd2}},
		// Mass bin boundaries, a few ordinary fills and reads, and a read beyond the table.
		'{'{OP_FILL, 16'd10239, 16'd122, 3'd3, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b0, '0},
		'{'{OP_FILL, 16'd10239, 16'd123, 3'd4, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b0, '0},
		'{'{OP_FILL, 16'd12287, 16'd3072, 3'd6, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b0, '0},
		'{'{OP_FILL, 16'd35840, 16'h8000, 3'd2, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0},
		  1'b0, '0},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0},
		  1'b1, '{1'b0, 1'b0, 5'd0, 6'd0, 32'd1}},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd27, 6'd49},
		  1'b1, '{1'b0, 1'b1, 5'd27, 6'd49, 32'd1}},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd14, 6'd1},
		  1'b0, '0},
		'{'{OP_FILL, 16'h5555, 16'hAAAA, 3'd5, 1'b1, 1'b0, 1'b1, 1'b1, 5'd21, 6'd42},
		  1'b0, '0},
		'{'{OP_READ, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd28, 6'd51},
		  1'b1, '{1'b0, 1'b0, 5'd28, 6'd51, 32'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = 3'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [15:0] pair_pt = 16'd0;
	logic [15:0] pair_mass = 16'd0;
	logic [2:0]  sector = 3'd0;
	logic        trigger_first = 1'b0;
	logic        trigger_second = 1'b0;
	logic        event_live = 1'b0;
	logic        read_group = 1'b0;
	logic [4:0]  read_pt_bin = 5'd0;
	logic [5:0]  read_mass_bin = 6'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic        group;
	logic [4:0]  pt_bin_found;
	logic [5:0]  mass_bin_found;
	logic [31:0] count;

	pair_mass_histogrammer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pair_pt        (pair_pt),
		.pair_mass      (pair_mass),
		.sector         (sector),
		.trigger_first  (trigger_first),
		.trigger_second (trigger_second),
		.event_live     (event_live),
		.read_group     (read_group),
		.read_pt_bin    (read_pt_bin),
		.read_mass_bin  (read_mass_bin),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.accepted       (accepted),
		.group          (group),
		.pt_bin_found   (pt_bin_found),
		.mass_bin_found (mass_bin_found),
		.count          (count)
	);

	logic [31:0] mirror_counts [2][PT_ROWS][MASS_COLS + 1];
	logic [2:0]  sector_limit = 3'd5;
	result_t     pending_results [$];
	result_t     recent_hits [8];
	int          hit_next = 0;
	logic [15:0] hot_pt [4];
	logic [15:0] hot_mass [4];
	int          burst_left = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	logic [31:0] stall_pattern = 32'd0;
	int          stall_left = 0;
	result_t     oldest;

	always #10 clk = ~clk;

	// Updates the counter copy for one request and returns the result it should produce.
	function automatic result_t bin_request(req_t r);
		result_t    res;
		int         pb;
		int         b;
		logic       grp;
		logic [5:0] mb;
		res = '0;
		if (r.op == OP_READ) begin
			res.group = r.rd_group;
			res.pt_bin = r.rd_pt;
			res.mass_bin = r.rd_mass;
			if (r.rd_pt < PT_ROWS && r.rd_mass <= MASS_COLS)
				res.count = mirror_counts[r.rd_group][r.rd_pt][r.rd_mass];
			return res;
		end
		if (!((r.trig_a || r.trig_b) && r.live))
			return res;
		pb = -1;
		for (b = 0; b < PT_ROWS; b++) begin
			if (r.pt >= PT_EDGE_TAB[b] && r.pt < PT_EDGE_TAB[b + 1])
				pb = b;
		end
		if (pb < 0)
			return res;
		grp = (r.sector > sector_limit);
		if (r.mass >= MASS_SPAN)
			mb = 6'(MASS_COLS);
		else
			mb = 6'((32'(r.mass) * MASS_COLS) / MASS_SPAN);
		if (mirror_counts[grp][pb][mb] != 32'hFFFF_FFFF)
			mirror_counts[grp][pb][mb] = mirror_counts[grp][pb][mb] + 32'd1;
		res.accepted = 1'b1;
		res.group = grp;
		res.pt_bin = 5'(pb);
		res.mass_bin = mb;
		res.count = mirror_counts[grp][pb][mb];
		return res;
	endfunction

	// Mostly well-formed fills, some aimed at a few busy bins, reads that often target recently
	// filled counters, and some raw noise in every field.
	function automatic req_t random_request();
		req_t        r;
		result_t     h;
		logic [63:0] raw;
		int          pick;
		raw = {$urandom, $urandom};
		r = raw[$bits(req_t) - 1:0];
		if ($urandom_range(0, 9) < 4) begin
			r.op = OP_READ;
			if ($urandom_range(0, 9) < 6) begin
				h = recent_hits[$urandom_range(0, 7)];
				r.rd_group = h.group;
				r.rd_pt = h.pt_bin;
				r.rd_mass = h.mass_bin;
			end
			return r;
		end
		r.op = OP_FILL;
		if ($urandom_range(0, 9) < 8) begin
			r.live = 1'b1;
			r.trig_a = 1'($urandom_range(0, 1));
			r.trig_b = r.trig_a ? 1'($urandom_range(0, 1)) : 1'b1;
		end
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			r.pt = hot_pt[$urandom_range(0, 3)];
			r.mass = hot_mass[$urandom_range(0, 3)];
			return r;
		end
		if (pick < 7)
			r.pt = 16'($urandom_range(2560, 46079));
		else if (pick < 9)
			r.pt = 16'(PT_EDGE_TAB[$urandom_range(0, 28)] + $urandom_range(0, 2) - 1);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			r.mass = 16'($urandom_range(0, 6143));
		else if (pick < 7)
			r.mass = 16'(6143 + $urandom_range(0, 1));
		return r;
	endfunction

	// Offers one request, waits for it to be taken, then books its expected result.
	task automatic issue(req_t r, logic typed, result_t want);
		result_t predicted;
		in_valid <= 1'b1;
		operation <= r.op;
		pair_pt <= r.pt;
		pair_mass <= r.mass;
		sector <= r.sector;
		trigger_first <= r.trig_a;
		trigger_second <= r.trig_b;
		event_live <= r.live;
		read_group <= r.rd_group;
		read_pt_bin <= r.rd_pt;
		read_mass_bin <= r.rd_mass;
		do @(posedge clk); while (in_stall);
		predicted = bin_request(r);
		pending_results.push_back(typed ? want : predicted);
		if (predicted.accepted) begin
			recent_hits[hit_next] = predicted;
			hit_next = (hit_next + 1) % 8;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// The receiver stalls on a rotating bit pattern, re-drawn every so often; an all-zero
	// pattern gives stretches with no stall at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern <= 32'd0;
				1: stall_pattern <= $urandom;
				2: stall_pattern <= $urandom & $urandom;
				default: stall_pattern <= $urandom | $urandom;
			endcase
			stall_left <= $urandom_range(16, 120);
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
			stall_left <= stall_left - 1;
		end
		out_stall <= stall_pattern[0];
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got count %0d", $time, count);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("accepted", 32'(oldest.accepted), 32'(accepted));
				check_field("group", 32'(oldest.group), 32'(group));
				check_field("pt_bin_found", 32'(oldest.pt_bin), 32'(pt_bin_found));
				check_field("mass_bin_found", 32'(oldest.mass_bin), 32'(mass_bin_found));
				check_field("count", oldest.count, count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		foreach (mirror_counts[g, p, m])
			mirror_counts[g][p][m] = 32'd0;
		foreach (recent_hits[i])
			recent_hits[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			issue(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

		// The first phase keeps the sector split from reset; later ones move it to both
		// extremes and then somewhere in between.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				repeat (8) @(posedge clk);
				sector_limit = (phase == 1) ? 3'd0 : (phase == 2) ? 3'd7
					: 3'($urandom_range(1, 6));
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= sector_limit;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
			end
			foreach (hot_pt[i]) begin
				hot_pt[i] = 16'($urandom_range(2560, 46079));
				hot_mass[i] = 16'($urandom_range(0, 7000));
			end
			repeat (PHASE_ITEMS)
				issue(random_request(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/pmh_pkg.sv
hdl/pmh_ram.sv
hdl/pmh_ctrl.sv
hdl/pmh_dpath.sv
hdl/pair_mass_histogrammer.sv
tb/pair_mass_histogrammer_test.sv
